>>> rtl/rsie_pkg.sv
// ============================================================================
// rsie_pkg: shared definitions of the instruction executor
// Opcode and function codes, decoded operation kinds and the structures that
// travel between the front end, the back end and the result queue.
// ============================================================================
package rsie_pkg;

   localparam int unsigned REG_COUNT          = 32;
   localparam int unsigned RF_AW              = 5;
   localparam int unsigned DATA_DEPTH_DEFAULT = 256;
   localparam int unsigned QUEUE_DEPTH        = 2;
   localparam int unsigned QPTR_W             = 1;

   localparam logic [31:0] PC_RESET     = 32'h1000_0000;
   localparam logic [31:0] SYS_PRINT    = 32'd34;
   localparam logic [31:0] SYS_EXIT     = 32'd10;

   localparam logic [5:0] OPC_RTYPE = 6'b000000;
   localparam logic [5:0] OPC_J     = 6'b000010;
   localparam logic [5:0] OPC_BEQ   = 6'b000100;
   localparam logic [5:0] OPC_ADDIU = 6'b001001;
   localparam logic [5:0] OPC_LW    = 6'b100011;
   localparam logic [5:0] OPC_SW    = 6'b101011;

   localparam logic [5:0] FN_ADD     = 6'b100000;
   localparam logic [5:0] FN_SUB     = 6'b100010;
   localparam logic [5:0] FN_AND     = 6'b100100;
   localparam logic [5:0] FN_OR      = 6'b100101;
   localparam logic [5:0] FN_SLT     = 6'b101010;
   localparam logic [5:0] FN_SYSCALL = 6'b001100;

   typedef enum logic [3:0] {
      K_NOP, K_ADD, K_SUB, K_AND, K_OR, K_SLT, K_SYS,
      K_ADDIU, K_LW, K_SW, K_BEQ, K_J
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [RF_AW-1:0]  rs;
      logic [RF_AW-1:0]  rt;
      logic [RF_AW-1:0]  dest;
      logic [15:0]       imm;
      logic [25:0]       target;
   } dec_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        print_valid;
      logic [31:0] print_value;
      logic        halted;
      logic        mem_fault;
   } rsp_type;

endpackage

>>> rtl/risc_subset_instruction_executor_top.sv
// ============================================================================
// risc_subset_instruction_executor_top: 32-bit instruction executor
// Executes one instruction word per transaction and returns one result each.
// ============================================================================
// Each accepted instruction transaction yields exactly one result
// transaction carrying the new program counter, a print event, the halt flag
// and a memory fault flag. Instructions are decoded on entry and wait in a
// two-entry issue queue; the back end reads operands, executes and writes the
// register file back over three stages with full forwarding, so a new
// instruction is taken every clock cycle while the result queue has room;
// the other exception is a load whose destination is read by the very next
// instruction, which waits until the load leaves the execute stage, as the
// data memory read is registered. After reset the block clears its register
// file and data memory, one entry per cycle; full stays high during that
// time. Results wait in a two-entry queue, so the input side keeps flowing
// while a result waits to be popped. After a halt system call every further
// instruction changes nothing and reports the frozen program counter.
module risc_subset_instruction_executor_top
   import rsie_pkg::*;
#(
   parameter int unsigned DATA_DEPTH = DATA_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [31:0] req_instr_word,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_print_valid,
   output logic [31:0] rsp_print_value,
   output logic        rsp_halted,
   output logic        rsp_mem_fault
);

   logic    q_full, busy, deq, head_valid, rsp_full, rsp_push;
   dec_type head;
   rsp_type rsp_in, rsp_out;

   // The input is refused while the issue queue is full or the post-reset
   // clear is still running.
   assign full = q_full || busy;

   rsie_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (push && !full),
      .instr      (req_instr_word),
      .q_full     (q_full),
      .deq        (deq),
      .head       (head),
      .head_valid (head_valid)
   );

   rsie_back #(.DATA_DEPTH(DATA_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .deq        (deq),
      .busy       (busy),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp        (rsp_in)
   );

   // Result queue: decouples execution from the consumer's pop.
   rsie_queue #(.WIDTH($bits(rsp_type))) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (rsp_in),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_out),
      .empty   (empty)
   );

   assign rsp_next_pc     = rsp_out.next_pc;
   assign rsp_print_valid = rsp_out.print_valid;
   assign rsp_print_value = rsp_out.print_value;
   assign rsp_halted      = rsp_out.halted;
   assign rsp_mem_fault   = rsp_out.mem_fault;

endmodule

>>> rtl/rsie_queue.sv
// ============================================================================
// rsie_queue: two-entry queue
// Small first-in first-out buffer; a write and a read may share a cycle.
// ============================================================================
module rsie_queue
   import rsie_pkg::*;
#(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   logic [WIDTH-1:0]  slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_wr, do_rd;

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/rsie_front.sv
// ============================================================================
// rsie_front: instruction decode and issue queue
// Classifies each accepted instruction word and buffers it for the back end.
// ============================================================================
module rsie_front
   import rsie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] instr,
   output logic        q_full,
   input  logic        deq,
   output dec_type     head,
   output logic        head_valid
);

   dec_type     dec;
   logic        q_empty;
   logic [5:0]  opc, funct;

   assign opc   = instr[31:26];
   assign funct = instr[5:0];

   always_comb begin
      dec.kind   = K_NOP;
      dec.rs     = instr[25:21];
      dec.rt     = instr[20:16];
      dec.dest   = instr[15:11];
      dec.imm    = instr[15:0];
      dec.target = instr[25:0];
      case (opc)
         OPC_RTYPE: begin
            if (funct == FN_SYSCALL) begin
               // The system call reads its code and argument through the
               // ordinary operand ports.
               dec.kind = K_SYS;
               dec.rs   = RF_AW'(2);
               dec.rt   = RF_AW'(4);
            end else if (dec.dest != '0) begin
               case (funct)
                  FN_ADD:  dec.kind = K_ADD;
                  FN_SUB:  dec.kind = K_SUB;
                  FN_AND:  dec.kind = K_AND;
                  FN_OR:   dec.kind = K_OR;
                  FN_SLT:  dec.kind = K_SLT;
                  default: dec.kind = K_NOP;
               endcase
            end
         end
         OPC_J:     dec.kind = K_J;
         OPC_ADDIU: begin
            dec.kind = K_ADDIU;
            dec.dest = instr[20:16];
         end
         OPC_LW: begin
            dec.kind = K_LW;
            dec.dest = instr[20:16];
         end
         OPC_SW:    dec.kind = K_SW;
         OPC_BEQ:   dec.kind = K_BEQ;
         default:   dec.kind = K_NOP;
      endcase
   end

   rsie_queue #(.WIDTH($bits(dec_type))) u_issue_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (in_valid),
      .wr_data (dec),
      .full    (q_full),
      .rd_en   (deq),
      .rd_data (head),
      .empty   (q_empty)
   );

   assign head_valid = !q_empty;

endmodule

>>> rtl/rsie_back.sv
// ============================================================================
// rsie_back: execution back end
// Register file, data memory and program counter; operand read, execute and
// register write-back stages with forwarding, plus the post-reset clear.
// ============================================================================
module rsie_back
   import rsie_pkg::*;
#(
   parameter int unsigned DATA_DEPTH = DATA_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  dec_type head,
   input  logic    head_valid,
   output logic    deq,
   output logic    busy,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp
);

   localparam int unsigned AW      = $clog2(DATA_DEPTH);
   localparam int unsigned CLR_LEN = (DATA_DEPTH > REG_COUNT) ? DATA_DEPTH : REG_COUNT;
   localparam int unsigned CW      = $clog2(CLR_LEN);

   logic [31:0] rf [REG_COUNT];
   logic [31:0] dmem [DATA_DEPTH];

   logic        clr_ff, clr_in;
   logic [CW-1:0] clr_cnt_ff, clr_cnt_in;

   logic        e_valid_ff, e_valid_in;
   dec_type     e_dec_ff;
   logic [31:0] ra_raw_ff, rb_raw_ff, fa_ff, fb_ff;
   logic        fa_sel_ff, fb_sel_ff;
   logic [31:0] pc_ff, pc_in;
   logic        halt_ff, halt_in;

   logic        w_we_ff;
   logic [RF_AW-1:0] w_addr_ff;
   logic [31:0] w_alu_ff, dmem_rd_ff;
   logic        w_load_ff, w_fault_ff;
   logic [31:0] w_data;

   logic [31:0] a, b, imm32, addr, pc4, alu;
   logic        in_range, e_we, e_load, dm_sw, fault, pv;
   logic [31:0] pval;
   logic        e_fire, hazard, e_fwd_ok;
   logic        fa_sel_in, fb_sel_in;
   logic [31:0] fa_in, fb_in;

   logic             rf_we;
   logic [RF_AW-1:0] rf_waddr;
   logic [31:0]      rf_wdata;
   logic             dmem_we;
   logic [AW-1:0]    dmem_addr, e_word;
   logic [31:0]      dmem_wdata;

   // ---------------------------------------------------------------- execute
   always_comb begin
      a        = fa_sel_ff ? fa_ff : ra_raw_ff;
      b        = fb_sel_ff ? fb_ff : rb_raw_ff;
      imm32    = {{16{e_dec_ff.imm[15]}}, e_dec_ff.imm};
      addr     = a + imm32;
      e_word   = addr[AW+1:2];
      in_range = !addr[31] && (addr[30:2] < 29'(DATA_DEPTH));
      pc4      = pc_ff + 32'd4;
      pc_in    = pc4;
      halt_in  = halt_ff;
      alu      = '0;
      e_we     = 1'b0;
      e_load   = 1'b0;
      dm_sw    = 1'b0;
      fault    = 1'b0;
      pv       = 1'b0;
      pval     = '0;
      if (halt_ff) begin
         pc_in = pc_ff;
      end else begin
         case (e_dec_ff.kind)
            K_ADD:   begin alu = a + b; e_we = 1'b1; end
            K_SUB:   begin alu = a - b; e_we = 1'b1; end
            K_AND:   begin alu = a & b; e_we = 1'b1; end
            K_OR:    begin alu = a | b; e_we = 1'b1; end
            K_SLT:   begin alu = {31'b0, $signed(a) < $signed(b)}; e_we = 1'b1; end
            K_ADDIU: begin alu = a + imm32; e_we = 1'b1; end
            K_LW: begin
               e_load = 1'b1;
               e_we   = 1'b1;
               fault  = !in_range;
            end
            K_SW: begin
               fault = !in_range;
               dm_sw = in_range;
            end
            K_BEQ: begin
               if (a == b) begin
                  pc_in = pc4 + {imm32[29:0], 2'b00};
               end
            end
            K_J:     pc_in = {pc4[31:28], e_dec_ff.target, 2'b00};
            K_SYS: begin
               if (a == SYS_PRINT) begin
                  pv   = 1'b1;
                  pval = b;
               end else if (a == SYS_EXIT) begin
                  halt_in = 1'b1;
                  pc_in   = pc_ff;
               end
            end
            default: pc_in = pc4;
         endcase
      end
      e_we = e_we && (e_dec_ff.dest != '0);
   end

   assign e_fire   = e_valid_ff && !rsp_full;
   assign rsp_push = e_fire;
   assign rsp      = '{next_pc: pc_in, print_valid: pv, print_value: pval,
                       halted: halt_in, mem_fault: fault};

   // ------------------------------------------------------ issue and forward
   assign hazard   = e_valid_ff && e_we && e_load &&
                     (e_dec_ff.dest == head.rs || e_dec_ff.dest == head.rt);
   assign deq      = head_valid && !clr_ff && (!e_valid_ff || e_fire) && !hazard;
   assign busy     = clr_ff;
   assign e_fwd_ok = e_fire && e_we && !e_load;
   assign w_data   = w_load_ff ? (w_fault_ff ? '0 : dmem_rd_ff) : w_alu_ff;

   always_comb begin
      fa_sel_in = 1'b1;
      fa_in     = w_data;
      if (e_fwd_ok && e_dec_ff.dest == head.rs) begin
         fa_in = alu;
      end else if (!(w_we_ff && w_addr_ff == head.rs)) begin
         fa_sel_in = 1'b0;
      end
      fb_sel_in = 1'b1;
      fb_in     = w_data;
      if (e_fwd_ok && e_dec_ff.dest == head.rt) begin
         fb_in = alu;
      end else if (!(w_we_ff && w_addr_ff == head.rt)) begin
         fb_sel_in = 1'b0;
      end
   end

   always_comb begin
      e_valid_in = e_valid_ff;
      if (deq) begin
         e_valid_in = 1'b1;
      end else if (e_fire) begin
         e_valid_in = 1'b0;
      end
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == CW'(CLR_LEN - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
         e_valid_ff <= 1'b0;
         w_we_ff    <= 1'b0;
         pc_ff      <= PC_RESET;
         halt_ff    <= 1'b0;
      end else begin
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
         e_valid_ff <= e_valid_in;
         w_we_ff    <= e_fire && e_we;
         if (e_fire) begin
            pc_ff   <= pc_in;
            halt_ff <= halt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (deq) begin
         e_dec_ff  <= head;
         fa_sel_ff <= fa_sel_in;
         fb_sel_ff <= fb_sel_in;
         fa_ff     <= fa_in;
         fb_ff     <= fb_in;
      end
      if (e_fire) begin
         w_addr_ff  <= e_dec_ff.dest;
         w_alu_ff   <= alu;
         w_load_ff  <= e_load;
         w_fault_ff <= fault;
      end
   end

   // --------------------------------------------------------------- memories
   always_comb begin
      if (clr_ff) begin
         rf_we      = ({1'b0, clr_cnt_ff} < (CW+1)'(REG_COUNT));
         rf_waddr   = clr_cnt_ff[RF_AW-1:0];
         rf_wdata   = '0;
         dmem_we    = ({1'b0, clr_cnt_ff} < (CW+1)'(DATA_DEPTH));
         dmem_addr  = clr_cnt_ff[AW-1:0];
         dmem_wdata = '0;
      end else begin
         rf_we      = w_we_ff;
         rf_waddr   = w_addr_ff;
         rf_wdata   = w_data;
         dmem_we    = e_fire && dm_sw;
         dmem_addr  = e_word;
         dmem_wdata = b;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf[rf_waddr] <= rf_wdata;
      end
      if (deq) begin
         ra_raw_ff <= rf[head.rs];
         rb_raw_ff <= rf[head.rt];
      end
   end

   always_ff @(posedge clock) begin
      if (dmem_we) begin
         dmem[dmem_addr] <= dmem_wdata;
      end
      if (e_fire && e_load) begin
         dmem_rd_ff <= dmem[e_word];
      end
   end

   // ------------------------------------------------------------- assertions
   a_halt_pc_hold: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> $stable(pc_ff))
      else $error("program counter moved while halted");

   a_halt_no_store: assert property (@(posedge clock) disable iff (reset)
      (halt_ff && !clr_ff) |-> !dmem_we)
      else $error("data memory written while halted");

   a_clear_no_issue: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !deq)
      else $error("instruction issued during memory clear");

endmodule
